// ----- rtl/xct_pkg.sv -----
// Shared types, character codes and delimiter codes for the XML tokenizer.
package xct_pkg;

    // Default sizes
    localparam int XCT_POSITION_BITS = 20;
    localparam int XCT_QUEUE_DEPTH   = 4;
    localparam int XCT_OFFSET_BITS   = 20;

    // Character codes
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Delimiter codes as reported on the output
    localparam logic [2:0] PC_LT       = 3'd0;
    localparam logic [2:0] PC_GT       = 3'd1;
    localparam logic [2:0] PC_QUESTION = 3'd2;
    localparam logic [2:0] PC_BANG     = 3'd3;
    localparam logic [2:0] PC_EQUAL    = 3'd4;
    localparam logic [2:0] PC_SLASH    = 3'd5;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } t_quote;

    typedef enum logic [1:0] {
        T_NONE  = 2'd0,
        T_OPEN  = 2'd1,
        T_CLOSE = 2'd2
    } t_tag;

    // Classification of one byte, produced by the front end
    typedef struct packed {
        logic       sod;
        logic       ws;
        logic       squote;
        logic       dquote;
        logic       backslash;
        logic       punct_hit;
        logic [2:0] punct_code;
    } t_char_class;

endpackage

// ----- rtl/xct_front.sv -----
// Front end: accepts bytes, classifies them and stamps each with its offset.
module xct_front #(
    parameter int POSITION_BITS = xct_pkg::XCT_POSITION_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [7:0]                 i_byte_value,
    input  logic                       i_start_of_document,
    output xct_pkg::t_char_class       o_class,
    output logic [POSITION_BITS-1:0]   o_position
);
    import xct_pkg::*;

    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] base_pos;

    // Offset of this byte; start of document restarts at zero
    assign base_pos   = i_start_of_document ? '0 : r_pos;
    assign o_position = base_pos;
    assign n_pos      = (&base_pos) ? base_pos : base_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    // Byte classification
    always_comb begin
        o_class            = '0;
        o_class.sod        = i_start_of_document;
        o_class.ws         = i_byte_value inside {CH_SPACE, [CH_TAB:CH_CR]};
        o_class.squote     = (i_byte_value == CH_SQUOTE);
        o_class.dquote     = (i_byte_value == CH_DQUOTE);
        o_class.backslash  = (i_byte_value == CH_BACKSLASH);
        o_class.punct_hit  = 1'b1;
        case (i_byte_value)
            CH_LT:       o_class.punct_code = PC_LT;
            CH_GT:       o_class.punct_code = PC_GT;
            CH_QUESTION: o_class.punct_code = PC_QUESTION;
            CH_BANG:     o_class.punct_code = PC_BANG;
            CH_EQUAL:    o_class.punct_code = PC_EQUAL;
            CH_SLASH:    o_class.punct_code = PC_SLASH;
            default: begin
                o_class.punct_hit  = 1'b0;
                o_class.punct_code = PC_LT;
            end
        endcase
    end

endmodule

// ----- rtl/xct_queue.sv -----
// Short queue of classified words between front end and back end.
module xct_queue #(
    parameter int POSITION_BITS = xct_pkg::XCT_POSITION_BITS,
    parameter int QUEUE_DEPTH   = xct_pkg::XCT_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  xct_pkg::t_char_class       i_class,
    input  logic [POSITION_BITS-1:0]   i_position,
    input  logic                       i_pop,
    output logic                       o_full,
    output logic                       o_empty,
    output xct_pkg::t_char_class       o_class,
    output logic [POSITION_BITS-1:0]   o_position
);
    import xct_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

    t_char_class              r_class [QUEUE_DEPTH];
    logic [POSITION_BITS-1:0] r_pos   [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]      r_wr_ptr;
    logic [PTR_BITS-1:0]      r_rd_ptr;
    logic [CNT_BITS-1:0]      r_count;
    logic [PTR_BITS-1:0]      n_wr_ptr;
    logic [PTR_BITS-1:0]      n_rd_ptr;
    logic [CNT_BITS-1:0]      n_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign o_class    = r_class[r_rd_ptr];
    assign o_position = r_pos[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_class[r_wr_ptr] <= i_class;
            r_pos[r_wr_ptr]   <= i_position;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !i_pop)
        else $error("pop from empty queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");
`endif

endmodule

// ----- rtl/xct_back.sv -----
// Back end: quote, tag and token tracking with a registered result word.
module xct_back #(
    parameter int POSITION_BITS = xct_pkg::XCT_POSITION_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_word_valid,
    input  xct_pkg::t_char_class                   i_class,
    input  logic [POSITION_BITS-1:0]               i_position,
    output logic                                   o_pop,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic                                   o_text_valid,
    output logic [xct_pkg::XCT_OFFSET_BITS-1:0]    o_text_start,
    output logic [xct_pkg::XCT_OFFSET_BITS-1:0]    o_text_length,
    output logic                                   o_punct_valid,
    output logic [2:0]                             o_punct_code,
    output logic [xct_pkg::XCT_OFFSET_BITS-1:0]    o_punct_position
);
    import xct_pkg::*;

    localparam int OW = XCT_OFFSET_BITS;
    localparam int EW = OW + POSITION_BITS;

    // Tokenizer state
    t_quote                   r_quote;
    t_tag                     r_tag;
    logic                     r_prev_bs;
    logic                     r_has_content;
    logic [POSITION_BITS-1:0] r_tok_begin;
    t_quote                   n_quote;
    t_tag                     n_tag;
    logic                     n_prev_bs;
    logic                     n_has_content;
    logic [POSITION_BITS-1:0] n_tok_begin;

    // Result register
    logic                     r_out_valid;
    logic                     r_text_valid;
    logic [OW-1:0]            r_text_start;
    logic [OW-1:0]            r_text_length;
    logic                     r_punct_valid;
    logic [2:0]               r_punct_code;
    logic [OW-1:0]            r_punct_position;

    // Current state, with start of document applied
    t_quote                   cur_quote;
    t_tag                     cur_tag;
    logic                     cur_prev_bs;
    logic                     cur_has_content;
    logic [POSITION_BITS-1:0] cur_tok_begin;

    logic                     ends;
    logic                     text_hit;
    logic                     punct_hit;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] tok_len;
    logic [EW-1:0]            ext_start;
    logic [EW-1:0]            ext_len;
    logic [EW-1:0]            ext_pos;

    assign o_pop = i_word_valid && (!r_out_valid || !i_out_stall);

    assign cur_quote       = i_class.sod ? Q_NONE : r_quote;
    assign cur_tag         = i_class.sod ? T_NONE : r_tag;
    assign cur_prev_bs     = i_class.sod ? 1'b0 : r_prev_bs;
    assign cur_has_content = i_class.sod ? 1'b0 : r_has_content;
    assign cur_tok_begin   = i_class.sod ? '0 : r_tok_begin;

    assign pos_inc = (&i_position) ? i_position : i_position + 1'b1;

    // Next-state logic
    always_comb begin
        n_quote       = cur_quote;
        n_tag         = cur_tag;
        n_prev_bs     = i_class.backslash;
        n_has_content = cur_has_content;
        n_tok_begin   = cur_tok_begin;
        ends          = 1'b0;
        punct_hit     = 1'b0;

        // quote tracking, one byte of escape look-back
        if (i_class.squote && cur_quote != Q_DOUBLE && !cur_prev_bs) begin
            n_quote = (cur_quote == Q_NONE) ? Q_SINGLE : Q_NONE;
        end else if (i_class.dquote && cur_quote != Q_SINGLE && !cur_prev_bs) begin
            n_quote = (cur_quote == Q_NONE) ? Q_DOUBLE : Q_NONE;
        end

        // boundaries only outside quotes
        if (n_quote == Q_NONE) begin
            if (cur_tag == T_OPEN && i_class.ws) begin
                ends = 1'b1;
            end else if (i_class.punct_hit &&
                         (i_class.punct_code == PC_LT || i_class.punct_code == PC_GT ||
                          cur_tag == T_OPEN)) begin
                ends      = 1'b1;
                punct_hit = 1'b1;
                if (i_class.punct_code == PC_LT) begin
                    n_tag = T_OPEN;
                end else if (i_class.punct_code == PC_GT) begin
                    n_tag = T_CLOSE;
                end
            end
        end

        if (ends) begin
            n_tok_begin   = pos_inc;
            n_has_content = 1'b0;
        end else if (!i_class.ws) begin
            n_has_content = 1'b1;
        end
    end

    // Result logic
    always_comb begin
        text_hit  = ends && cur_has_content;
        tok_len   = (i_position > cur_tok_begin) ? i_position - cur_tok_begin : '0;
        ext_start = {{OW{1'b0}}, (text_hit ? cur_tok_begin : {POSITION_BITS{1'b0}})};
        ext_len   = {{OW{1'b0}}, (text_hit ? tok_len : {POSITION_BITS{1'b0}})};
        ext_pos   = {{OW{1'b0}}, (punct_hit ? i_position : {POSITION_BITS{1'b0}})};
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote       <= Q_NONE;
            r_tag         <= T_NONE;
            r_prev_bs     <= 1'b0;
            r_has_content <= 1'b0;
            r_tok_begin   <= '0;
        end else if (o_pop) begin
            r_quote       <= n_quote;
            r_tag         <= n_tag;
            r_prev_bs     <= n_prev_bs;
            r_has_content <= n_has_content;
            r_tok_begin   <= n_tok_begin;
        end
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= text_hit || punct_hit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_text_valid     <= text_hit;
            r_text_start     <= ext_start[OW-1:0];
            r_text_length    <= ext_len[OW-1:0];
            r_punct_valid    <= punct_hit;
            r_punct_code     <= punct_hit ? i_class.punct_code : PC_LT;
            r_punct_position <= ext_pos[OW-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_text_valid     = r_text_valid;
    assign o_text_start     = r_text_start;
    assign o_text_length    = r_text_length;
    assign o_punct_valid    = r_punct_valid;
    assign o_punct_code     = r_punct_code;
    assign o_punct_position = r_punct_position;

`ifndef ASSERT_OFF
    a_word_has_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_text_valid || r_punct_valid))
        else $error("result word with no token");
    a_no_token_in_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_quote != Q_NONE && !i_class.sod && !i_class.squote &&
         !i_class.dquote) |=> !r_out_valid)
        else $error("token found inside quotes");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_text_start) &&
                                          $stable(r_punct_position)))
        else $error("stalled result word lost or changed");
`endif

endmodule

// ----- rtl/xml_character_tokenizer.sv -----
// An accepted byte enters the queue; its result word is registered as the back end pops it.
// Throughput: one byte per cycle while o_in_stall is low; the back end state update is combinational.
// A four-word queue parts the front end from the back end, so the input keeps
// flowing while a result word waits on a stalled output, until the queue fills.
// Reset: synchronous, active low; clears offsets, quote, tag and token state and the queue.
module xml_character_tokenizer #(
    parameter int POSITION_BITS = xct_pkg::XCT_POSITION_BITS,
    parameter int QUEUE_DEPTH   = xct_pkg::XCT_QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [7:0]                             i_byte_value,
    input  logic                                   i_start_of_document,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_text_valid,
    output logic [xct_pkg::XCT_OFFSET_BITS-1:0]    o_text_start,
    output logic [xct_pkg::XCT_OFFSET_BITS-1:0]    o_text_length,
    output logic                                   o_punct_valid,
    output logic [2:0]                             o_punct_code,
    output logic [xct_pkg::XCT_OFFSET_BITS-1:0]    o_punct_position
);
    import xct_pkg::*;

    logic                     accept;
    logic                     q_full;
    logic                     q_empty;
    logic                     pop;
    t_char_class              front_class;
    logic [POSITION_BITS-1:0] front_pos;
    t_char_class              head_class;
    logic [POSITION_BITS-1:0] head_pos;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    xct_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (accept),
        .i_byte_value        (i_byte_value),
        .i_start_of_document (i_start_of_document),
        .o_class             (front_class),
        .o_position          (front_pos)
    );

    xct_queue #(
        .POSITION_BITS(POSITION_BITS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_class    (front_class),
        .i_position (front_pos),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .o_class    (head_class),
        .o_position (head_pos)
    );

    xct_back #(
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_word_valid     (!q_empty),
        .i_class          (head_class),
        .i_position       (head_pos),
        .o_pop            (pop),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_text_valid     (o_text_valid),
        .o_text_start     (o_text_start),
        .o_text_length    (o_text_length),
        .o_punct_valid    (o_punct_valid),
        .o_punct_code     (o_punct_code),
        .o_punct_position (o_punct_position)
    );

endmodule
